@@ hw/rtl/abc_pkg.sv @@
// Shared widths, codes and helpers for the adaptive batch coalescer.
`timescale 1ns / 1ps
`default_nettype none

package abc_pkg;

  localparam int unsigned THR_W     = 11;
  localparam int unsigned FLIGHT_W  = 16;
  localparam int unsigned BASE_W    = 32;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned THREADS_W = 9;
  localparam int unsigned PROD_W    = THR_W + FLIGHT_W;

  localparam int unsigned MAX_BATCH     = 1024;
  localparam int unsigned MAX_IN_FLIGHT = 65535;
  localparam int unsigned THR_STEP      = 4;

  localparam int unsigned RESET_INIT_THR = 16;
  localparam int unsigned RESET_CAPACITY = 257;
  localparam int unsigned RESET_THREADS  = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 2'd0,
    CMD_RECYCLE = 2'd1,
    CMD_FLUSH   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_COLLECTOR = 2'd0,
    REG_INIT_THR  = 2'd1,
    REG_CAPACITY  = 2'd2,
    REG_THREADS   = 2'd3
  } reg_idx_t;

  // Zero maps to one, anything above the largest batch saturates.
  function automatic logic [THR_W-1:0] clamp_initial(input logic [THR_W-1:0] v);
    logic [THR_W-1:0] r;
    r = v;
    if (v == '0) r = THR_W'(1);
    else if (v > THR_W'(MAX_BATCH)) r = THR_W'(MAX_BATCH);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/adaptive_batch_coalescer.sv @@
// Top level of the adaptive batch coalescer: sequencer, state and register port.
`timescale 1ns / 1ps
`default_nettype none

//  channel | signals                                  | direction | transfer when
//  --------+------------------------------------------+-----------+----------------------
//  input   | in_valid/in_ready, cmd, item_handle, urg | in        | in_valid & in_ready
//  result  | out_valid/out_ready, slot_*, dispatch_*  | out       | out_valid & out_ready
//  config  | psel, penable, pwrite, paddr, pwdata     | in        | psel&penable&pwrite
//
//  Add without dispatch, empty flush and the unused command go straight to the result state.
//  Dispatch or recycle add start, divider load, divide, done and update steps before the result,
//  and the next item waits for them; the shared divider retires one bit per cycle of the
//  27-bit product threshold * in_flight.
//  in_ready is high only while the sequencer idles; a held result in the output
//  register does not block the next transfer, only the hand-over of a new result.
//  Synchronous reset loads register defaults and state; no clearing pass.

module adaptive_batch_coalescer
  import abc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [CMD_W-1:0]     cmd,
  input  wire logic [HANDLE_W-1:0]  item_handle,
  input  wire logic                 urgent,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      slot_valid,
  output logic [THR_W-1:0]          slot_index,
  output logic [HANDLE_W-1:0]       item_echo,
  output logic                      dispatched,
  output logic [BASE_W-1:0]         dispatch_base,
  output logic [THR_W-1:0]          dispatch_count,
  output logic                      dispatch_urgent,
  output logic [THR_W-1:0]          threshold_now,
  output logic [FLIGHT_W-1:0]       batches_in_flight,
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  state_t state;

  // configuration
  logic                 collector;
  logic [THR_W-1:0]     init_thr;
  logic [THR_W-1:0]     capacity;
  logic [THREADS_W-1:0] threads;

  // coalescer state
  logic [THR_W-1:0]     fill;
  logic [THR_W-1:0]     open_thr;
  logic [THR_W-1:0]     mgr;
  logic [FLIGHT_W-1:0]  in_flight;
  logic [BASE_W-1:0]    open_base;

  // result being built for the item in work
  logic                 res_slot_valid;
  logic [THR_W-1:0]     res_slot;
  logic [HANDLE_W-1:0]  res_echo;
  logic                 res_disp;
  logic [BASE_W-1:0]    res_base;
  logic [THR_W-1:0]     res_count;
  logic                 res_urg;

  // divider hook-up
  logic                 div_start;
  logic [PROD_W-1:0]    div_dividend;
  logic [THREADS_W-1:0] div_divisor;
  logic [PROD_W-1:0]    div_quot;
  logic                 div_done;

  logic                 cfg_write;
  reg_idx_t             cfg_idx;
  logic                 acc;
  cmd_t                 cmd_c;
  logic [THR_W-1:0]     fill_inc;
  logic                 acc_disp;
  logic [THR_W-1:0]     acc_count;
  logic                 acc_urg;
  logic                 raise_ok;
  logic [THR_W:0]       rnd;
  logic [THR_W:0]       rnd_up;
  logic [THR_W-1:0]     raise_val;
  logic                 lower_ok;
  logic [THR_W-1:0]     lower_val;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign cmd_c     = cmd_t'(cmd);
  assign fill_inc  = fill + THR_W'(1);

  always_comb begin
    case (cfg_idx)
      REG_COLLECTOR: prdata = 32'(collector);
      REG_INIT_THR:  prdata = 32'(init_thr);
      REG_CAPACITY:  prdata = 32'(capacity);
      REG_THREADS:   prdata = 32'(threads);
      default:       prdata = '0;
    endcase
  end

  // What an accepted item does to the open batch.
  always_comb begin
    acc_disp  = 1'b0;
    acc_count = fill;
    acc_urg   = 1'b0;
    case (cmd_c)
      CMD_ADD: begin
        acc_count = fill_inc;
        if (fill_inc >= open_thr) begin
          acc_disp = 1'b1;
          acc_urg  = urgent;
        end
      end
      CMD_FLUSH: acc_disp = (fill != '0);
      default:   acc_disp = 1'b0;
    endcase
  end

  // Threshold adaptation from the scaled value n = mgr * in_flight / threads.
  always_comb begin
    raise_ok  = !collector && (div_quot < PROD_W'(capacity))
                && ({1'b0, div_quot} > (PROD_W + 1)'(mgr) + (PROD_W + 1)'(THR_STEP));
    // n is below capacity here, so its low bits carry it whole
    rnd       = {1'b0, div_quot[THR_W-1:0]} + (THR_W + 1)'(THR_STEP - 1);
    rnd_up    = {rnd[THR_W:2], 2'b00};
    raise_val = (rnd_up > (THR_W + 1)'(MAX_BATCH)) ? THR_W'(MAX_BATCH) : rnd_up[THR_W-1:0];
    lower_ok  = !collector && (div_quot > PROD_W'(THR_STEP))
                && (({1'b0, div_quot} + (PROD_W + 1)'(THR_STEP)) < (PROD_W + 1)'(mgr));
    lower_val = {div_quot[THR_W-1:2], 2'b00};
  end

  assign div_start    = (state == S_START);
  assign div_dividend = PROD_W'(mgr) * PROD_W'(in_flight);
  assign div_divisor  = (threads == '0) ? THREADS_W'(1) : threads;

  abc_divider #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (THREADS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      collector <= 1'b0;
      init_thr  <= THR_W'(RESET_INIT_THR);
      capacity  <= THR_W'(RESET_CAPACITY);
      threads   <= THREADS_W'(RESET_THREADS);
      fill      <= '0;
      open_thr  <= clamp_initial(THR_W'(RESET_INIT_THR));
      mgr       <= clamp_initial(THR_W'(RESET_INIT_THR));
      in_flight <= '0;
      open_base <= '0;
    end else begin
      // a result handed over in S_FIN takes the output register itself
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;

      // register writes must come only while the block is idle; the block does not enforce this
      if (cfg_write) begin
        case (cfg_idx)
          REG_COLLECTOR: collector <= pwdata[0];
          REG_INIT_THR: begin
            init_thr <= pwdata[THR_W-1:0];
            open_thr <= clamp_initial(pwdata[THR_W-1:0]);
            mgr      <= clamp_initial(pwdata[THR_W-1:0]);
          end
          REG_CAPACITY:  capacity <= pwdata[THR_W-1:0];
          REG_THREADS:   threads  <= pwdata[THREADS_W-1:0];
          default:       collector <= collector;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (acc) begin
            res_slot_valid <= (cmd_c == CMD_ADD);
            res_slot       <= (cmd_c == CMD_ADD) ? fill : '0;
            res_echo       <= (cmd_c == CMD_ADD) ? item_handle : '0;
            res_disp       <= acc_disp;
            res_base       <= acc_disp ? open_base : '0;
            res_count      <= acc_disp ? acc_count : '0;
            res_urg        <= acc_disp && acc_urg;
            if (acc_disp) begin
              // new batch opens on the manager threshold before adaptation
              fill      <= '0;
              open_base <= open_base + BASE_W'(open_thr);
              open_thr  <= mgr;
            end else if (cmd_c == CMD_ADD) begin
              fill <= fill_inc;
            end
            state <= (acc_disp || cmd_c == CMD_RECYCLE) ? S_START : S_FIN;
          end
        end
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_done) state <= S_UPD;
        end
        S_UPD: begin
          if (res_disp) begin
            if (raise_ok) mgr <= raise_val;
            if (in_flight != FLIGHT_W'(MAX_IN_FLIGHT)) in_flight <= in_flight + FLIGHT_W'(1);
          end else begin
            if (lower_ok) mgr <= lower_val;
            if (in_flight != '0) in_flight <= in_flight - FLIGHT_W'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            slot_valid        <= res_slot_valid;
            slot_index        <= res_slot;
            item_echo         <= res_echo;
            dispatched        <= res_disp;
            dispatch_base     <= res_base;
            dispatch_count    <= res_count;
            dispatch_urgent   <= res_urg;
            threshold_now     <= mgr;
            batches_in_flight <= in_flight;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // manager threshold stays within one and the largest batch
  a_mgr_range: assert property (@(posedge clk) disable iff (rst)
    (mgr != '0) && (mgr <= THR_W'(MAX_BATCH)))
    else $error("manager threshold out of range");

  // every accepted transfer takes ready low in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    acc |=> !in_ready)
    else $error("ready held across an accepted transfer");

  // in-flight count moves by at most one per step
  a_flight_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (in_flight == $past(in_flight))
      || (in_flight == $past(in_flight) + FLIGHT_W'(1))
      || (in_flight == $past(in_flight) - FLIGHT_W'(1)))
    else $error("in-flight count jumped");

  // the divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

@@ hw/rtl/abc_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module abc_divider
  import abc_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = PROD_W,
  parameter int unsigned DIVISOR_W  = THREADS_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0]      quotient,
  output logic                       done
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   rem_sh;
  logic                 fits;
  logic [DIVISOR_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem, quotient[DIVIDEND_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the adaptive batch coalescer: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import abc_pkg::*;

  localparam int unsigned CLK_HALF     = 10;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_IDLE     = 12;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned REPORT_CAP   = 200;
  // the command encoding leaves one code spare; the block must treat it as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one result transfer, fields in port order
  typedef struct packed {
    logic                slot_valid;
    logic [THR_W-1:0]    slot_index;
    logic [HANDLE_W-1:0] item_echo;
    logic                dispatched;
    logic [BASE_W-1:0]   dispatch_base;
    logic [THR_W-1:0]    dispatch_count;
    logic                dispatch_urgent;
    logic [THR_W-1:0]    threshold_now;
    logic [FLIGHT_W-1:0] batches_in_flight;
  } coalesce_result_t;

  // a row of the directed table: either a register write or one input transfer
  typedef struct {
    bit                  is_write;
    reg_idx_t            reg_sel;
    logic [31:0]         wdata;
    logic [CMD_W-1:0]    op;
    logic [HANDLE_W-1:0] handle;
    logic                urg;
    bit                  known;
    coalesce_result_t    want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] item_handle;
  logic                urgent;
  logic                out_valid;
  logic                out_ready;
  logic                slot_valid;
  logic [THR_W-1:0]    slot_index;
  logic [HANDLE_W-1:0] item_echo;
  logic                dispatched;
  logic [BASE_W-1:0]   dispatch_base;
  logic [THR_W-1:0]    dispatch_count;
  logic                dispatch_urgent;
  logic [THR_W-1:0]    threshold_now;
  logic [FLIGHT_W-1:0] batches_in_flight;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  adaptive_batch_coalescer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .item_handle(item_handle), .urgent(urgent),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_valid(slot_valid), .slot_index(slot_index), .item_echo(item_echo),
    .dispatched(dispatched), .dispatch_base(dispatch_base),
    .dispatch_count(dispatch_count), .dispatch_urgent(dispatch_urgent),
    .threshold_now(threshold_now), .batches_in_flight(batches_in_flight),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Mirror of the block: registers first, then batch state.
  logic                mir_collector;
  logic [THR_W-1:0]    mir_init_thr;
  logic [THR_W-1:0]    mir_capacity;
  logic [THREADS_W-1:0] mir_threads;
  logic [THR_W-1:0]    mir_fill;
  logic [THR_W-1:0]    mir_open_thr;
  logic [THR_W-1:0]    mir_mgr_thr;
  logic [FLIGHT_W-1:0] mir_in_flight;
  logic [BASE_W-1:0]   mir_base;

  coalesce_result_t pending_results[$];  // oldest expected transfer at the front
  stim_row_t        directed_rows[$];

  // shared between the stimulus, the receiver and the scoreboard
  bit               known_valid;    // typed-in expectation for the item on the bus
  coalesce_result_t known_result;
  bit               tx_idle_on;
  bit               rx_idle_on;
  int               rx_hold;
  int               mismatches;
  int               results_seen;
  int               cycle_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_result(input coalesce_result_t got, input coalesce_result_t want);
    string tag;
    tag = $sformatf("(result %0d)", results_seen);
    if (got.slot_valid !== want.slot_valid)
      report_mismatch($sformatf("slot_valid got %0h exp %0h %s",
                                got.slot_valid, want.slot_valid, tag));
    if (got.slot_index !== want.slot_index)
      report_mismatch($sformatf("slot_index got %0h exp %0h %s",
                                got.slot_index, want.slot_index, tag));
    if (got.item_echo !== want.item_echo)
      report_mismatch($sformatf("item_echo got %0h exp %0h %s",
                                got.item_echo, want.item_echo, tag));
    if (got.dispatched !== want.dispatched)
      report_mismatch($sformatf("dispatched got %0h exp %0h %s",
                                got.dispatched, want.dispatched, tag));
    if (got.dispatch_base !== want.dispatch_base)
      report_mismatch($sformatf("dispatch_base got %0h exp %0h %s",
                                got.dispatch_base, want.dispatch_base, tag));
    if (got.dispatch_count !== want.dispatch_count)
      report_mismatch($sformatf("dispatch_count got %0h exp %0h %s",
                                got.dispatch_count, want.dispatch_count, tag));
    if (got.dispatch_urgent !== want.dispatch_urgent)
      report_mismatch($sformatf("dispatch_urgent got %0h exp %0h %s",
                                got.dispatch_urgent, want.dispatch_urgent, tag));
    if (got.threshold_now !== want.threshold_now)
      report_mismatch($sformatf("threshold_now got %0h exp %0h %s",
                                got.threshold_now, want.threshold_now, tag));
    if (got.batches_in_flight !== want.batches_in_flight)
      report_mismatch($sformatf("batches_in_flight got %0h exp %0h %s",
                                got.batches_in_flight, want.batches_in_flight, tag));
  endtask

  // Advances the mirror by one accepted command and returns the transfer it should produce.
  task automatic coalesce_step(input logic [CMD_W-1:0] op, input logic [HANDLE_W-1:0] h,
                               input logic u, output coalesce_result_t r);
    logic              fire;
    logic              d_urg;
    longint unsigned   div;
    longint unsigned   n;
    r     = '0;
    fire  = 1'b0;
    d_urg = 1'b0;
    // scaled threshold uses state from before this step; a zero thread count divides by one
    div = (mir_threads == 0) ? 64'd1 : 64'(mir_threads);
    n   = (64'(mir_mgr_thr) * 64'(mir_in_flight)) / div;
    if (op == CMD_ADD) begin
      r.slot_valid = 1'b1;
      r.slot_index = mir_fill;
      r.item_echo  = h;
      mir_fill     = mir_fill + THR_W'(1);
      if (mir_fill >= mir_open_thr) begin
        fire  = 1'b1;
        d_urg = u;
      end
    end else if (op == CMD_RECYCLE) begin
      // shrink only on a clear drop, never below four
      if (!mir_collector && n > THR_STEP && n + THR_STEP < mir_mgr_thr)
        mir_mgr_thr = THR_W'(n - n % THR_STEP);
      if (mir_in_flight != 0) mir_in_flight = mir_in_flight - FLIGHT_W'(1);
    end else if (op == CMD_FLUSH) begin
      fire = (mir_fill != 0);
    end
    if (fire) begin
      r.dispatched      = 1'b1;
      r.dispatch_base   = mir_base;
      r.dispatch_count  = mir_fill;
      r.dispatch_urgent = d_urg;
      mir_base     = mir_base + BASE_W'(mir_open_thr);
      mir_open_thr = mir_mgr_thr;  // new batch takes the pre-update threshold
      mir_fill     = '0;
      if (!mir_collector && n < mir_capacity && n > mir_mgr_thr + THR_STEP) begin
        if (n % THR_STEP != 0) n = n + THR_STEP - n % THR_STEP;
        if (n > MAX_BATCH) n = MAX_BATCH;
        mir_mgr_thr = THR_W'(n);
      end
      if (mir_in_flight < MAX_IN_FLIGHT) mir_in_flight = mir_in_flight + FLIGHT_W'(1);
    end
    r.threshold_now     = mir_mgr_thr;
    r.batches_in_flight = mir_in_flight;
  endtask

  // Drop valid and wait until every expected transfer is back; the block is then idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup and access phases, mirror updated on the write edge.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_COLLECTOR: mir_collector = v[0];
      REG_INIT_THR: begin
        mir_init_thr = v[THR_W-1:0];
        if (mir_init_thr == 0) mir_open_thr = THR_W'(1);
        else if (mir_init_thr > MAX_BATCH) mir_open_thr = THR_W'(MAX_BATCH);
        else mir_open_thr = mir_init_thr;
        mir_mgr_thr = mir_open_thr;
      end
      REG_CAPACITY:  mir_capacity = v[THR_W-1:0];
      REG_THREADS:   mir_threads  = v[THREADS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [HANDLE_W-1:0] h,
                           input logic u, input bit known, input coalesce_result_t want);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    known_valid  = known;
    known_result = want;
    cmd         <= op;
    item_handle <= h;
    urgent      <= u;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic void add_row(input bit is_write, input reg_idx_t idx,
                                  input logic [31:0] v, input logic [CMD_W-1:0] op,
                                  input logic [HANDLE_W-1:0] h, input logic u,
                                  input bit known, input coalesce_result_t want);
    stim_row_t x;
    x.is_write = is_write;
    x.reg_sel  = idx;
    x.wdata    = v;
    x.op       = op;
    x.handle   = h;
    x.urg      = u;
    x.known    = known;
    x.want     = want;
    directed_rows.push_back(x);
  endfunction

  function automatic void row_write(input reg_idx_t idx, input logic [31:0] v);
    add_row(1'b1, idx, v, CMD_UNUSED, '0, 1'b0, 1'b0, '0);
  endfunction

  function automatic void row_item(input logic [CMD_W-1:0] op, input logic [HANDLE_W-1:0] h,
                                   input logic u);
    add_row(1'b0, REG_COLLECTOR, '0, op, h, u, 1'b0, '0);
  endfunction

  function automatic void row_known(input logic [CMD_W-1:0] op, input logic [HANDLE_W-1:0] h,
                                    input logic u, input int sv, input int si, input int echo,
                                    input int disp, input int base, input int cnt,
                                    input int du, input int thr, input int fl);
    coalesce_result_t w;
    w.slot_valid        = sv[0];
    w.slot_index        = THR_W'(si);
    w.item_echo         = HANDLE_W'(echo);
    w.dispatched        = disp[0];
    w.dispatch_base     = BASE_W'(base);
    w.dispatch_count    = THR_W'(cnt);
    w.dispatch_urgent   = du[0];
    w.threshold_now     = THR_W'(thr);
    w.batches_in_flight = FLIGHT_W'(fl);
    add_row(1'b0, REG_COLLECTOR, '0, op, h, u, 1'b1, w);
  endfunction

  // Receiver: after each result transfer, hold ready low for a drawn number of cycles.
  initial begin : receiver
    out_ready = 1'b0;
    rx_hold   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Scoreboard: outputs and handshakes sampled on the rising edge.
  // Result side is handled before the input side so a same-edge push never pairs with itself.
  always @(posedge clk) begin : scoreboard
    coalesce_result_t got;
    coalesce_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {slot_valid, slot_index, item_echo, dispatched, dispatch_base,
               dispatch_count, dispatch_urgent, threshold_now, batches_in_flight};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result transfer %0d with nothing expected",
                                    results_seen));
        end else begin
          want = pending_results.pop_front();
          compare_result(got, want);
        end
        results_seen++;
        rx_hold = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (in_valid && in_ready) begin
        coalesce_step(cmd, item_handle, urgent, want);
        if (known_valid) want = known_result;
        pending_results.push_back(want);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t        row;
    coalesce_result_t none;
    int               add_lim;
    int               rec_lim;
    int               flush_lim;
    int               r;
    logic [CMD_W-1:0] op;
    logic [31:0]      v;

    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_ADD;
    item_handle  = '0;
    urgent       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    known_valid  = 1'b0;
    known_result = '0;
    none         = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    mismatches   = 0;
    results_seen = 0;
    cycle_count  = 0;

    // register defaults and state as left by reset
    mir_collector = 1'b0;
    mir_init_thr  = THR_W'(RESET_INIT_THR);
    mir_capacity  = THR_W'(RESET_CAPACITY);
    mir_threads   = THREADS_W'(RESET_THREADS);
    mir_open_thr  = THR_W'(RESET_INIT_THR);
    mir_mgr_thr   = THR_W'(RESET_INIT_THR);
    mir_fill      = '0;
    mir_in_flight = '0;
    mir_base      = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Typed-in rows hold values readable straight off the defaults;
    // the rest go through the mirror.
    //         op           handle    u  sv si echo  d  base cnt du thr fl
    row_known(CMD_ADD,     16'hFFFF, 1, 1, 0, 'hFFFF, 0, 0, 0, 0, 16, 0);
    row_known(CMD_ADD,     16'h0000, 0, 1, 1, 'h0000, 0, 0, 0, 0, 16, 0);
    // flush carries no priority even with urgent set
    row_known(CMD_FLUSH,   16'h1234, 1, 0, 0, 0,      1, 0, 2, 0, 16, 1);
    // empty flush: nothing leaves, threshold untouched
    row_known(CMD_FLUSH,   16'h0000, 0, 0, 0, 0,      0, 0, 0, 0, 16, 1);
    // spare code: only threshold and in-flight reported
    row_known(CMD_UNUSED,  16'hABCD, 1, 0, 0, 0,      0, 0, 0, 0, 16, 1);
    row_known(CMD_RECYCLE, 16'h5A5A, 1, 0, 0, 0,      0, 0, 0, 0, 16, 0);
    // recycle with nothing in flight holds at zero
    row_known(CMD_RECYCLE, 16'hA5A5, 0, 0, 0, 0,      0, 0, 0, 0, 16, 0);
    // zero initial threshold reads as one: every add dispatches
    row_write(REG_INIT_THR, 32'd0);
    row_known(CMD_ADD,     16'h5555, 1, 1, 0, 'h5555, 1, 16, 1, 1, 1, 1);
    // zero thread count, widest capacity: thresholds climb 8 -> 16 -> 48 -> 192 -> 960
    row_write(REG_THREADS, 32'd0);
    row_write(REG_CAPACITY, 32'd2047);
    row_write(REG_INIT_THR, 32'd8);
    row_item(CMD_ADD, 16'h0001, 0);
    row_item(CMD_ADD, 16'h0002, 1);
    row_item(CMD_FLUSH, 16'h0000, 0);
    row_item(CMD_ADD, 16'h8000, 1);
    row_item(CMD_FLUSH, 16'h0000, 0);
    row_item(CMD_ADD, 16'h7FFF, 0);
    row_item(CMD_FLUSH, 16'h0000, 1);
    row_item(CMD_ADD, 16'h00FF, 1);
    row_item(CMD_FLUSH, 16'h0000, 0);
    row_item(CMD_ADD, 16'hFF00, 0);
    row_item(CMD_FLUSH, 16'h0000, 0);
    // widest thread count: recycle rounds the threshold down to a multiple of four
    row_write(REG_THREADS, 32'd511);
    row_item(CMD_RECYCLE, 16'h0000, 0);
    // collector mode freezes the threshold both ways
    row_write(REG_COLLECTOR, 32'd1);
    row_item(CMD_ADD, 16'h1111, 1);
    row_item(CMD_FLUSH, 16'h0000, 0);
    row_item(CMD_RECYCLE, 16'h0000, 0);
    row_write(REG_COLLECTOR, 32'd0);
    // oversize initial threshold saturates; a raise past the largest batch saturates too
    row_write(REG_THREADS, 32'd3);
    row_write(REG_INIT_THR, 32'd2047);
    row_item(CMD_ADD, 16'hFFFF, 1);
    row_item(CMD_FLUSH, 16'h0000, 0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) cfg_write(row.reg_sel, row.wdata);
      else send_item(row.op, row.handle, row.urg, row.known, row.want);
    end

    // Random phases: fresh settings each time but for an initial threshold sometimes kept, extremes
    // favoured, command mix varied so that in-flight count both builds up and drains.
    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_write(REG_COLLECTOR, 32'($urandom_range(0, 3) == 0));
      case ($urandom_range(0, 5))
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = 32'd511;
        3:       v = 32'd256;
        default: v = $urandom_range(2, 8);
      endcase
      cfg_write(REG_THREADS, v);
      case ($urandom_range(0, 4))
        0:       v = 32'd2047;
        1:       v = 32'd2;
        2:       v = 32'd1025;
        3:       v = 32'd0;
        default: v = $urandom_range(16, 600);
      endcase
      cfg_write(REG_CAPACITY, v);
      // sometimes keep the adapted threshold from the previous phase
      if (ph == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0:       v = 32'd0;
          1:       v = 32'd2047;
          2:       v = 32'd1024;
          3:       v = $urandom_range(9, 300);
          default: v = $urandom_range(1, 8);
        endcase
        cfg_write(REG_INIT_THR, v);
      end

      tx_idle_on = (ph % 4) != 1;
      rx_idle_on = (ph % 4) != 1 && (ph % 4) != 2;
      case ($urandom_range(0, 2))
        0: begin add_lim = 55; rec_lim = 70; flush_lim = 90; end  // balanced
        1: begin add_lim = 60; rec_lim = 65; flush_lim = 95; end  // batches pile up
        default: begin add_lim = 40; rec_lim = 85; flush_lim = 95; end  // drain
      endcase

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // now and then let the result side run dry before the next transfer
        if ($urandom_range(0, 39) == 0) settle();
        r = $urandom_range(0, 99);
        if (r < add_lim) op = CMD_ADD;
        else if (r < rec_lim) op = CMD_RECYCLE;
        else if (r < flush_lim) op = CMD_FLUSH;
        else op = CMD_UNUSED;
        send_item(op, HANDLE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, none);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
